/* hdl/hrl_pkg.sv */
`default_nettype none
package hrl_pkg;
    localparam logic [2:0] EV_ACK      = 3'd0;
    localparam logic [2:0] EV_NACK     = 3'd1;
    localparam logic [2:0] EV_UNLOCKED = 3'd2;
    localparam logic [2:0] EV_DATA     = 3'd3;
    localparam logic [2:0] EV_END      = 3'd4;

    localparam logic [1:0] CFG_KEY  = 2'd0;
    localparam logic [1:0] CFG_GAP  = 2'd1;
    localparam logic [1:0] CFG_IDLE = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_A  = 8'h41;

    localparam int unsigned MAX_RESULTS = 18;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY,
        ST_REC_RD,
        ST_REC_HI,
        ST_REC_LO,
        ST_REC_CHK,
        ST_EMIT_ONE,
        ST_EMIT_TWO,
        ST_DATA_RD,
        ST_DATA_HI,
        ST_DATA_LO,
        ST_DATA_OUT
    } state_t;

    typedef struct packed {
        logic       clr_line;
        logic       store_char;
        logic       rd_start;
        logic       rd_hi;
        logic       rd_lo;
        logic       clr_acc;
        logic       set_unlocked;
        logic       set_upper;
        logic       push;
        logic [2:0] push_kind;
        logic       push_data;
        logic       push_last;
        logic       key_step;
        logic       key_start;
        logic       tick;
        logic       byte_in;
        logic       relock;
    } dp_cmd_t;

    typedef struct packed {
        logic       line_full;
        logic       line_started;
        logic       unlocked;
        logic       gap_hit;
        logic       idle_hit;
        logic       key_ok;
        logic       key_done;
        logic       key_short;
        logic       rec_shape_ok;
        logic       rec_more;
        logic       rec_valid;
        logic [7:0] rec_type;
        logic [7:0] rec_cnt;
        logic       data_more;
        logic       data_last;
        logic       out_free;
    } dp_stat_t;
endpackage
`default_nettype wire

/* hdl/hex_record_line_loader_core.sv */
// A nack for an overlong line or a gap goes from idle to ST_EMIT_ONE, which waits for
// a free output. A record line end reads each byte pair in ST_REC_RD, ST_REC_HI and
// ST_REC_LO, checks it in ST_REC_CHK, then gives each data result through ST_DATA_RD,
// ST_DATA_HI, ST_DATA_LO and ST_DATA_OUT and the ack after the last. A key line of
// KEY_CHARS or more goes through ST_KEY; a match yields an unlocked result and an ack.
// One beat per cycle is taken while idle; input holds while a line end or nack is worked
// off. Reset: synchronous active-low aresetn locks the block, clears counters and line.
`default_nettype none
module hex_record_line_loader_core
    import hrl_pkg::*;
#(
    parameter int unsigned MAX_LINE_CHARS = 46,
    parameter int unsigned KEY_CHARS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // rx_byte
    input  wire logic        s_tuser,  // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // target_address[31:0], data_byte[39:32]
    output logic [2:0]       m_tuser,  // event_kind
    output logic             m_tlast,  // last_of_run
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    logic [63:0] key_reg;
    logic [7:0]  gapl_reg;
    logic [15:0] idlel_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] o_addr;
    logic [7:0]  o_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= 64'd3544952156018063160;
            gapl_reg  <= 8'd100;
            idlel_reg <= 16'd2000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY:  key_reg   <= cfg_data;
                CFG_GAP:  gapl_reg  <= cfg_data[7:0];
                CFG_IDLE: idlel_reg <= cfg_data[15:0];
                default:  key_reg   <= key_reg;
            endcase
        end
    end

    hrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_byte  (s_tdata),
        .stat     (stat),
        .cmd      (cmd)
    );

    hrl_datapath #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS),
        .KEY_CHARS      (KEY_CHARS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rx_byte         (s_tdata),
        .access_key      (key_reg),
        .rx_gap_limit_ms (gapl_reg),
        .idle_limit_ms   (idlel_reg),
        .cmd             (cmd),
        .stat            (stat),
        .o_kind          (m_tuser),
        .o_addr          (o_addr),
        .o_data          (o_data),
        .o_last          (m_tlast),
        .o_valid         (m_tvalid),
        .o_ready         (m_tready)
    );

    assign m_tdata = {o_data, o_addr};

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> stat.out_free) else $error("push while output busy");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.push) else $error("input taken during emit");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
endmodule
`default_nettype wire

/* hdl/hrl_datapath.sv */
`default_nettype none
module hrl_datapath
    import hrl_pkg::*;
#(
    parameter int unsigned MAX_LINE_CHARS = 46,
    parameter int unsigned KEY_CHARS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [63:0] access_key,
    input  wire logic [7:0]  rx_gap_limit_ms,
    input  wire logic [15:0] idle_limit_ms,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_addr,
    output logic [7:0]       o_data,
    output logic             o_last,
    output logic             o_valid,
    input  wire logic        o_ready
);
    localparam int unsigned LW = $clog2(MAX_LINE_CHARS + 1);
    localparam int unsigned AW = $clog2(MAX_LINE_CHARS);
    localparam int unsigned KW = $clog2(KEY_CHARS + 1);

    logic [7:0]    mem [MAX_LINE_CHARS];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [KW-1:0] kidx_reg, kidx_next;
    logic          kok_reg, kok_next;
    logic          unl_reg, unl_next;
    logic          at_reg, at_next;
    logic [15:0]   upper_reg, upper_next;
    logic [7:0]    gap_reg, gap_next;
    logic [15:0]   idle_reg, idle_next;
    logic [7:0]    hi_reg, hi_next;
    logic [7:0]    sum_reg, sum_next;
    logic [5:0]    nb_reg, nb_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [7:0]    typ_reg, typ_next;
    logic [7:0]    a1_reg, a1_next;
    logic [7:0]    a2_reg, a2_next;
    logic [7:0]    d4_reg, d4_next;
    logic [7:0]    d5_reg, d5_next;
    logic [7:0]    dcnt_reg, dcnt_next;
    logic [31:0]   addr_reg, addr_next;
    logic [2:0]    ok_reg;
    logic [31:0]   oa_reg;
    logic [7:0]    od_reg;
    logic          ol_reg;
    logic [7:0]    dec_byte;
    logic [7:0]    key_ch;
    logic [LW-1:0] pairs;
    logic [AW-1:0] rd_addr;
    logic [7:0]    gap_inc;
    logic [15:0]   idle_inc;

    assign dec_byte = {hi_reg[3:0], 4'h0} | (rd_data_reg - CH_A);
    assign key_ch   = access_key[6'(56 - 8 * int'(kidx_reg)) +: 8];
    assign pairs    = len_reg - LW'(1);
    assign rd_addr  = ptr_next[AW-1:0];
    assign gap_inc  = (gap_reg != 8'hFF) ? gap_reg + 8'd1 : gap_reg;
    assign idle_inc = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_char) begin
            mem[len_reg[AW-1:0]] <= rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        kidx_next  = kidx_reg;
        kok_next   = kok_reg;
        unl_next   = unl_reg;
        at_next    = at_reg;
        upper_next = upper_reg;
        gap_next   = gap_reg;
        idle_next  = idle_reg;
        hi_next    = hi_reg;
        sum_next   = sum_reg;
        nb_next    = nb_reg;
        cnt_next   = cnt_reg;
        typ_next   = typ_reg;
        a1_next    = a1_reg;
        a2_next    = a2_reg;
        d4_next    = d4_reg;
        d5_next    = d5_reg;
        dcnt_next  = dcnt_reg;
        addr_next  = addr_reg;
        if (cmd.byte_in) begin
            gap_next  = '0;
            idle_next = '0;
        end
        if (cmd.tick) begin
            gap_next  = gap_inc;
            idle_next = idle_inc;
        end
        if (cmd.relock) begin
            unl_next  = 1'b0;
            gap_next  = '0;
            idle_next = '0;
        end
        if (cmd.store_char) begin
            len_next = len_reg + LW'(1);
            if (len_reg == '0) at_next = rx_byte == CH_AT;
        end
        if (cmd.key_start) begin
            kidx_next = '0;
            kok_next  = 1'b1;
            ptr_next  = '0;
        end
        if (cmd.key_step) begin
            if (rd_data_reg != key_ch) kok_next = 1'b0;
            kidx_next = kidx_reg + KW'(1);
            ptr_next  = ptr_reg + LW'(1);
        end
        if (cmd.rd_start) begin
            ptr_next = LW'(1);
            sum_next = '0;
            nb_next  = '0;
        end
        if (cmd.rd_hi) begin
            hi_next  = rd_data_reg - CH_A;
            ptr_next = ptr_reg + LW'(1);
        end
        if (cmd.rd_lo) begin
            ptr_next = ptr_reg + LW'(1);
            sum_next = sum_reg + dec_byte;
            nb_next  = nb_reg + 6'd1;
            unique case (nb_reg)
                6'd0: cnt_next = dec_byte;
                6'd1: a1_next  = dec_byte;
                6'd2: a2_next  = dec_byte;
                6'd3: typ_next = dec_byte;
                6'd4: d4_next  = dec_byte;
                6'd5: d5_next  = dec_byte;
                default: ;
            endcase
        end
        if (cmd.clr_acc) begin
            ptr_next  = LW'(9);
            dcnt_next = '0;
            addr_next = {upper_reg, a1_reg, a2_reg};
        end
        if (cmd.push && cmd.push_data) begin
            ptr_next  = ptr_reg + LW'(1);
            dcnt_next = dcnt_reg + 8'd1;
            addr_next = addr_reg + 32'd1;
        end
        if (cmd.set_unlocked) begin
            unl_next   = 1'b1;
            upper_next = '0;
        end
        if (cmd.set_upper) upper_next = {d4_reg, d5_reg};
        if (cmd.clr_line) begin
            len_next  = '0;
            gap_next  = '0;
            idle_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            unl_reg   <= 1'b0;
            upper_reg <= '0;
            gap_reg   <= '0;
            idle_reg  <= '0;
            o_valid   <= 1'b0;
        end else begin
            len_reg   <= len_next;
            unl_reg   <= unl_next;
            upper_reg <= upper_next;
            gap_reg   <= gap_next;
            idle_reg  <= idle_next;
            if (cmd.push) o_valid <= 1'b1;
            else if (o_ready) o_valid <= 1'b0;
        end
        ptr_reg  <= ptr_next;
        kidx_reg <= kidx_next;
        kok_reg  <= kok_next;
        at_reg   <= at_next;
        hi_reg   <= hi_next;
        sum_reg  <= sum_next;
        nb_reg   <= nb_next;
        cnt_reg  <= cnt_next;
        typ_reg  <= typ_next;
        a1_reg   <= a1_next;
        a2_reg   <= a2_next;
        d4_reg   <= d4_next;
        d5_reg   <= d5_next;
        dcnt_reg <= dcnt_next;
        addr_reg <= addr_next;
        if (cmd.push) begin
            ok_reg <= cmd.push_kind;
            oa_reg <= cmd.push_data ? addr_reg : 32'd0;
            od_reg <= cmd.push_data ? dec_byte : 8'd0;
            ol_reg <= cmd.push_last;
        end
    end

    assign o_kind = ok_reg;
    assign o_addr = oa_reg;
    assign o_data = od_reg;
    assign o_last = ol_reg;

    always_comb begin
        stat.line_full    = len_reg >= LW'(MAX_LINE_CHARS);
        stat.line_started = len_reg != '0;
        stat.unlocked     = unl_reg;
        stat.gap_hit      = gap_inc >= rx_gap_limit_ms;
        stat.idle_hit     = idle_inc >= idle_limit_ms;
        stat.key_ok       = kok_reg;
        stat.key_done     = kidx_reg == KW'(KEY_CHARS);
        stat.key_short    = len_reg < LW'(KEY_CHARS);
        stat.rec_shape_ok = len_reg != '0 && at_reg && !pairs[0] && pairs >= LW'(10);
        stat.rec_more     = ptr_reg + LW'(1) < len_reg;
        stat.rec_valid    = sum_reg == 8'd0 && {2'b00, nb_reg} == cnt_reg + 8'd5;
        stat.rec_type     = typ_reg;
        stat.rec_cnt      = cnt_reg;
        stat.data_more    = dcnt_reg < cnt_reg;
        stat.data_last    = dcnt_reg + 8'd1 == cnt_reg;
        stat.out_free     = !o_valid || o_ready;
    end
endmodule
`default_nettype wire

/* hdl/hrl_ctrl.sv */
`default_nettype none
module hrl_ctrl
    import hrl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_op,
    input  wire logic [7:0] in_byte,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd
);
    state_t state_reg, state_next;
    logic [2:0] k1_reg, k1_next;
    logic [2:0] k2_reg, k2_next;
    logic       prev_two_reg;
    logic       take;

    assign take = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        k1_reg <= k1_next;
        k2_reg <= k2_next;
    end

    always_comb begin
        state_next = state_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take && !in_op) begin
                    if (in_byte == CH_CR) begin
                        if (stat.unlocked) begin
                            if (stat.rec_shape_ok) begin
                                state_next = ST_REC_RD;
                            end else begin
                                k1_next = EV_NACK;
                                state_next = ST_EMIT_ONE;
                            end
                        end else if (!stat.key_short) begin
                            state_next = ST_KEY;
                        end
                    end else if (stat.line_full) begin
                        k1_next = EV_NACK;
                        state_next = ST_EMIT_ONE;
                    end
                end else if (take && in_op && stat.line_started && stat.gap_hit) begin
                    k1_next = EV_NACK;
                    state_next = ST_EMIT_ONE;
                end
            end
            ST_KEY: begin
                if (stat.key_done) begin
                    if (stat.key_ok) begin
                        k1_next = EV_UNLOCKED;
                        k2_next = EV_ACK;
                        state_next = ST_EMIT_TWO;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REC_RD: state_next = ST_REC_HI;
            ST_REC_HI: state_next = ST_REC_LO;
            ST_REC_LO: state_next = stat.rec_more ? ST_REC_RD : ST_REC_CHK;
            ST_REC_CHK: begin
                k1_next = EV_NACK;
                state_next = ST_EMIT_ONE;
                if (stat.rec_valid) begin
                    priority if (stat.rec_type == 8'd0 &&
                                 32'(stat.rec_cnt) + 32'd1 <= 32'(MAX_RESULTS)) begin
                        state_next = stat.rec_cnt == 8'd0 ? ST_EMIT_ONE : ST_DATA_RD;
                        k1_next = EV_ACK;
                    end else if (stat.rec_type == 8'd1) begin
                        k1_next = EV_END;
                        k2_next = EV_ACK;
                        state_next = ST_EMIT_TWO;
                    end else if (stat.rec_type == 8'd4 && stat.rec_cnt == 8'd2) begin
                        k1_next = EV_ACK;
                    end else begin
                        k1_next = EV_NACK;
                    end
                end
            end
            ST_EMIT_TWO: if (stat.out_free) state_next = ST_EMIT_ONE;
            ST_EMIT_ONE: if (stat.out_free) state_next = ST_IDLE;
            ST_DATA_RD: state_next = ST_DATA_HI;
            ST_DATA_HI: state_next = ST_DATA_LO;
            ST_DATA_LO: state_next = ST_DATA_OUT;
            ST_DATA_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.data_last ? ST_EMIT_ONE : ST_DATA_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = state_reg == ST_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    cmd.byte_in = !in_op;
                    cmd.tick    = in_op;
                    if (!in_op) begin
                        if (in_byte == CH_CR) begin
                            if (stat.unlocked) begin
                                cmd.rd_start = stat.rec_shape_ok;
                                cmd.clr_line = !stat.rec_shape_ok;
                            end else begin
                                cmd.key_start = !stat.key_short;
                                cmd.clr_line  = stat.key_short;
                            end
                        end else if (stat.line_full) begin
                            cmd.clr_line = 1'b1;
                        end else begin
                            cmd.store_char = 1'b1;
                        end
                    end else if (stat.line_started && stat.gap_hit) begin
                        cmd.clr_line = 1'b1;
                    end else if (stat.idle_hit) begin
                        cmd.clr_line = 1'b1;
                        cmd.relock   = 1'b1;
                    end
                end
            end
            ST_KEY: begin
                if (stat.key_done) begin
                    cmd.clr_line     = 1'b1;
                    cmd.set_unlocked = stat.key_ok;
                end else begin
                    cmd.key_step = 1'b1;
                end
            end
            ST_REC_RD: cmd = '0;
            ST_REC_HI: cmd.rd_hi = 1'b1;
            ST_REC_LO: cmd.rd_lo = 1'b1;
            ST_REC_CHK: begin
                cmd.clr_line  = 1'b1;
                cmd.clr_acc   = 1'b1;
                cmd.set_upper = stat.rec_valid && stat.rec_type == 8'd4 &&
                                stat.rec_cnt == 8'd2;
            end
            ST_EMIT_TWO: begin
                cmd.push      = stat.out_free;
                cmd.push_kind = k1_reg;
            end
            ST_EMIT_ONE: begin
                cmd.push      = stat.out_free;
                cmd.push_kind = prev_two_reg ? k2_reg : k1_reg;
                cmd.push_last = 1'b1;
            end
            ST_DATA_RD: cmd = '0;
            ST_DATA_HI: cmd.rd_hi = 1'b1;
            ST_DATA_LO: cmd = '0;
            ST_DATA_OUT: begin
                cmd.push      = stat.out_free;
                cmd.push_kind = EV_DATA;
                cmd.push_data = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_two_reg <= 1'b0;
        end else if (state_reg == ST_EMIT_TWO && stat.out_free) begin
            prev_two_reg <= 1'b1;
        end else if (state_reg == ST_EMIT_ONE && stat.out_free) begin
            prev_two_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* tb/hex_record_line_loader_core_test.sv */
`timescale 1ns / 1ps
module hex_record_line_loader_core_test;
    import hrl_pkg::*;

    localparam int LINE_MAX = 46;
    localparam int KEY_LEN = 8;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [7:0]  data;
        logic        last;
    } loader_event_t;

    class loader_scoreboard;
        logic [63:0] key;
        logic [7:0]  gap_limit;
        logic [15:0] idle_limit;
        bit          unlocked;
        logic [7:0]  line [LINE_MAX];
        int          line_len;
        logic [15:0] upper;
        logic [7:0]  gap_cnt;
        logic [15:0] idle_cnt;
        loader_event_t pending[$];
        int errors;

        function void reset_state();
            key = 64'd3544952156018063160;
            gap_limit = 8'd100;
            idle_limit = 16'd2000;
            unlocked = 0;
            line_len = 0;
            upper = 0;
            gap_cnt = 0;
            idle_cnt = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            if (idx == CFG_KEY) key = val;
            else if (idx == CFG_GAP) gap_limit = val[7:0];
            else if (idx == CFG_IDLE) idle_limit = val[15:0];
        endfunction

        function void push(logic [2:0] k, logic [31:0] a, logic [7:0] d);
            loader_event_t e;
            e.kind = k;
            e.addr = a;
            e.data = d;
            e.last = 0;
            pending.push_back(e);
        endfunction

        function void key_line();
            if (line_len < KEY_LEN) return;
            for (int i = 0; i < KEY_LEN; i++)
                if (line[i] != key[56-8*i +: 8]) return;
            unlocked = 1;
            upper = 0;
            push(EV_UNLOCKED, 0, 0);
            push(EV_ACK, 0, 0);
        endfunction

        function void record_line();
            logic [7:0] rec [LINE_MAX];
            logic [7:0] sum;
            logic [31:0] base;
            int nb;
            sum = 0;
            if (line_len == 0 || line[0] != CH_AT || ((line_len - 1) % 2) != 0) begin
                push(EV_NACK, 0, 0);
                return;
            end
            nb = (line_len - 1) / 2;
            if (nb < 5) begin
                push(EV_NACK, 0, 0);
                return;
            end
            for (int i = 0; i < nb; i++) begin
                rec[i] = ((line[1+2*i] - CH_A) << 4) | (line[2+2*i] - CH_A);
                sum += rec[i];
            end
            if (sum != 0 || rec[0] + 5 != nb) begin
                push(EV_NACK, 0, 0);
                return;
            end
            case (rec[3])
                8'd0: begin
                    if (rec[0] + 1 > MAX_RESULTS) begin
                        push(EV_NACK, 0, 0);
                        return;
                    end
                    base = {upper, 16'h0} + {rec[1], rec[2]};
                    for (int i = 0; i < rec[0]; i++) push(EV_DATA, base + i, rec[4+i]);
                    push(EV_ACK, 0, 0);
                end
                8'd1: begin
                    push(EV_END, 0, 0);
                    push(EV_ACK, 0, 0);
                end
                8'd4: begin
                    if (rec[0] != 2) push(EV_NACK, 0, 0);
                    else begin
                        upper = {rec[4], rec[5]};
                        push(EV_ACK, 0, 0);
                    end
                end
                default: push(EV_NACK, 0, 0);
            endcase
        endfunction

        function void note_input(logic op, logic [7:0] ch);
            int before_n;
            before_n = pending.size();
            if (!op) begin
                gap_cnt = 0;
                idle_cnt = 0;
                if (ch == CH_CR) begin
                    if (unlocked) record_line();
                    else key_line();
                    line_len = 0;
                end else if (line_len >= LINE_MAX) begin
                    push(EV_NACK, 0, 0);
                    line_len = 0;
                end else begin
                    line[line_len] = ch;
                    line_len++;
                end
            end else begin
                if (gap_cnt != 8'hFF) gap_cnt++;
                if (idle_cnt != 16'hFFFF) idle_cnt++;
                if (line_len > 0 && gap_cnt >= gap_limit) begin
                    push(EV_NACK, 0, 0);
                    line_len = 0;
                    gap_cnt = 0;
                    idle_cnt = 0;
                end else if (idle_cnt >= idle_limit) begin
                    unlocked = 0;
                    line_len = 0;
                    gap_cnt = 0;
                    idle_cnt = 0;
                end
            end
            if (pending.size() > before_n) pending[pending.size()-1].last = 1;
        endfunction

        function void check_result(loader_event_t got);
            loader_event_t exp_e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d addr=%h data=%h last=%b",
                         $realtime, got.kind, got.addr, got.data, got.last);
                errors++;
                return;
            end
            exp_e = pending.pop_front();
            if (got.kind != exp_e.kind) begin
                $display("%0t: kind expected %0d actual %0d", $realtime, exp_e.kind, got.kind);
                errors++;
            end
            if (got.addr != exp_e.addr) begin
                $display("%0t: address expected %h actual %h", $realtime, exp_e.addr, got.addr);
                errors++;
            end
            if (got.data != exp_e.data) begin
                $display("%0t: data expected %h actual %h", $realtime, exp_e.data, got.data);
                errors++;
            end
            if (got.last != exp_e.last) begin
                $display("%0t: last expected %b actual %b", $realtime, exp_e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [63:0] cfg_data = 0;

    loader_scoreboard sb;
    longint cycles = 0;
    bit hold_off = 0;
    bit sink_quiet = 0;
    int sent = 0;
    logic [63:0] cur_key;

    hex_record_line_loader_core dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sink: random stalls, with a long hold-off on request.
    always @(posedge aclk) begin
        loader_event_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.addr = m_tdata[31:0];
            got.data = m_tdata[39:32];
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    initial begin
        int r;
        forever begin
            @(negedge aclk);
            r = $urandom_range(0, 99);
            if (hold_off) m_tready <= 0;
            else if (sink_quiet || r < 70) m_tready <= 1;
            else if (r < 97) m_tready <= 0;
            else begin
                m_tready <= 0;
                repeat ($urandom_range(10, 60)) @(negedge aclk);
            end
        end
    end

    task automatic send_item(logic op, logic [7:0] ch);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 75) begin
            s_tvalid <= 0;
            repeat (r >= 98 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= ch;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, ch);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_char(logic [7:0] ch);
        send_item(1'b0, ch);
    endtask

    task automatic send_tick();
        send_item(1'b1, 8'($urandom()));
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 0;
        while (sb.pending.size() != 0 && n < 200000) begin
            @(negedge aclk);
            n++;
        end
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [63:0] val);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        if (idx == CFG_KEY) cur_key = val;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_key();
        for (int i = 0; i < KEY_LEN; i++) send_char(cur_key[56-8*i +: 8]);
        send_char(CH_CR);
    endtask

    task automatic send_byte_pair(logic [7:0] b);
        send_char(CH_A + b[7:4]);
        send_char(CH_A + b[3:0]);
    endtask

    // bad: 0 good, 1 checksum off, 2 count off, 3 odd char, 4 short
    task automatic send_record(logic [7:0] typ, int cnt, logic [15:0] addr, int bad);
        logic [7:0] rec [24];
        logic [7:0] sum;
        int nb;
        sum = 0;
        nb = cnt + 5;
        rec[0] = 8'((bad == 2) ? cnt + 1 : cnt);
        rec[1] = addr[15:8];
        rec[2] = addr[7:0];
        rec[3] = typ;
        for (int i = 0; i < cnt; i++) rec[4+i] = 8'($urandom());
        for (int i = 0; i < nb - 1; i++) sum += rec[i];
        rec[nb-1] = -sum + (bad == 1 ? 8'd1 : 8'd0);
        if (bad == 4) nb = $urandom_range(0, 4);
        send_char(CH_AT);
        for (int i = 0; i < nb; i++) send_byte_pair(rec[i]);
        if (bad == 3) send_char(CH_A + 8'($urandom_range(0, 15)));
        send_char(CH_CR);
    endtask

    task automatic send_random_record();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) send_record(8'd0, $urandom_range(0, 3) == 0 ? 16 : $urandom_range(0, 6),
                                16'($urandom()), 0);
        else if (r < 65) send_record(8'd4, 2, 16'($urandom()), 0);
        else if (r < 70) send_record(8'd1, 0, 16'($urandom()), 0);
        else if (r < 75) send_record(8'($urandom()), $urandom_range(0, 4), 16'($urandom()), 0);
        else if (r < 90) send_record(8'd0, $urandom_range(0, 6), 16'($urandom()),
                                     $urandom_range(1, 4));
        else begin
            repeat ($urandom_range(1, 12)) send_char(8'($urandom()));
            send_char(CH_CR);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        cur_key = sb.key;
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Locked: short key line, key mismatch, overlong line, then unlock.
        repeat (3) send_char("1");
        send_char(CH_CR);
        send_char("x");
        repeat (8) send_char("1");
        send_char(CH_CR);
        repeat (LINE_MAX + 1) send_char(8'($urandom()));
        send_char(CH_CR);
        send_key();
        send_record(8'd0, 16, 16'hFFFF, 0);
        send_record(8'd4, 2, 16'h0000, 0);
        send_record(8'd4, 3, 16'h0000, 0);
        send_record(8'd1, 0, 16'h1234, 0);
        send_record(8'd7, 1, 16'h0000, 0);
        send_record(8'd0, 0, 16'h0000, 0);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(CH_CR);
        send_char(CH_CR);

        write_cfg(CFG_GAP, 64'd1);
        write_cfg(CFG_IDLE, 64'd3);
        send_char(CH_AT);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        write_cfg(CFG_KEY, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cfg(CFG_IDLE, 64'd65535);
        write_cfg(CFG_GAP, 64'd255);
        send_key();

        // Long sink stall while sending records.
        fork
            begin
                hold_off = 1;
                repeat (600) @(negedge aclk);
                hold_off = 0;
            end
            repeat (2) send_record(8'd0, 2, 16'($urandom()), 0);
        join
        drain();

        for (int phase = 1; phase < 3; phase++) begin
            if (phase == 1) begin
                write_cfg(CFG_KEY, 64'h0);
                write_cfg(CFG_GAP, 64'($urandom_range(2, 6)));
                write_cfg(CFG_IDLE, 64'($urandom_range(8, 20)));
            end else if (phase == 2) begin
                write_cfg(CFG_KEY, {$urandom(), $urandom()});
                write_cfg(CFG_GAP, 64'd100);
                write_cfg(CFG_IDLE, 64'd2000);
            end
            send_key();
            sink_quiet = (phase == 2);
            for (int n = 0; n < 1; n++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 80) send_random_record();
                else if (r < 92) repeat ($urandom_range(1, 8)) send_tick();
                else if (r < 96) send_key();
                else begin
                    send_char(CH_AT);
                    repeat ($urandom_range(1, 10)) send_tick();
                end
                if (!sb.unlocked) send_key();
            end
        end
        sink_quiet = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

/* hex_record_line_loader_core.f */
hdl/hrl_pkg.sv
hdl/hrl_datapath.sv
hdl/hrl_ctrl.sv
hdl/hex_record_line_loader_core.sv
tb/hex_record_line_loader_core_test.sv
